@@ hdl/gaussian_variogram_eval_macros.svh @@
// Assertion helpers used by the checker module vge_chk
`ifndef GAUSSIAN_VARIOGRAM_EVAL_MACROS_SVH
`define GAUSSIAN_VARIOGRAM_EVAL_MACROS_SVH

// clocked assertion with asynchronous active-low reset disable
`define VGE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same, on the default checker clock and reset names
`define VGE_ASSERT_DEF(label, prop, msg) \
  `VGE_ASSERT(label, clk_i, rst_ni, prop, msg)

`endif

@@ hdl/vge_pkg.sv @@
// ----------------------------------------------------------------------------
// vge_pkg
// Types, constants and table helpers for the Gaussian variogram evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vge_pkg;

  typedef struct packed {
    logic               operation;
    logic signed [23:0] dx;
    logic signed [23:0] dy;
  } vge_req_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               saturated;
  } vge_rsp_t;

  typedef struct packed {
    logic op;
    logic near_zero;
  } vge_ctrl_t;

  typedef enum logic [1:0] {
    CFG_NUGGET = 2'd0,
    CFG_SILL   = 2'd1,
    CFG_RANGE  = 2'd2
  } vge_cfg_e;

  localparam int unsigned H2_W     = 48;
  localparam int unsigned R2_W     = 64;
  localparam int unsigned NUM_W    = 50;
  localparam int unsigned TQ_W     = 20;
  localparam int unsigned REM_W    = 84;
  localparam int unsigned E_W      = 17;
  localparam int unsigned F_W      = 20;
  localparam int unsigned SEG_SH   = 18;
  localparam int unsigned H2_SMALL = 430;
  localparam logic [16:0] E_ONE    = 17'd65536;

  // n / 3 by reciprocal multiply, exact over the full 32-bit range
  function automatic logic [31:0] div3(input logic [31:0] n);
    logic [63:0] p;
    p = 64'(n) * 64'hAAAA_AAAB;
    return {1'b0, p[63:33]};
  endfunction

  // shift-and-subtract quotient, only used while building the table
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned den);
    longint unsigned q, r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= den) begin
        r = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-12k/2^bits) in Q0.16, Taylor series and repeated squaring in Q.30
  function automatic logic [16:0] exp_entry(input int unsigned k, input int unsigned bits);
    longint unsigned y, even, odd, term, v;
    int unsigned i;
    y = ((longint'(3) * longint'(k) << 30) + (longint'(2) << bits)) >> (bits + 2);
    even = longint'(1) << 30;
    odd = 0;
    term = longint'(1) << 30;
    for (i = 1; i <= 24; i++) begin
      term = udiv64((term * y) >> 30, longint'(i));
      if (i[0]) odd += term;
      else even += term;
    end
    v = (even > odd) ? even - odd : 0;
    for (i = 0; i < 4; i++) v = (v * v + (longint'(1) << 29)) >> 30;
    return 17'((v + 8192) >> 14);
  endfunction

endpackage

@@ hdl/vge_sq.sv @@
// ----------------------------------------------------------------------------
// vge_sq
// Squared distance and squared range, one registered multiplier stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vge_sq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  vge_pkg::vge_req_t    req_i,
  input  logic [31:0]          range_i,
  output logic                 valid_o,
  output logic [47:0]          h2_o,
  output logic [63:0]          r2_o,
  output logic                 op_o
);
  import vge_pkg::*;

  logic              valid_q;
  logic [H2_W-1:0]   h2_q, h2_d;
  logic [R2_W-1:0]   r2_q, r2_d;
  logic              op_q;
  logic [31:0]       rr;
  logic [H2_W-1:0]   sx, sy;

  always_comb begin
    rr   = (range_i == 32'd0) ? 32'd1 : range_i;
    sx   = H2_W'($signed(req_i.dx) * $signed(req_i.dx));
    sy   = H2_W'($signed(req_i.dy) * $signed(req_i.dy));
    h2_d = sx + sy;
    r2_d = R2_W'(rr) * R2_W'(rr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h2_q <= h2_d;
      r2_q <= r2_d;
      op_q <= req_i.operation;
    end
  end

  assign valid_o = valid_q;
  assign h2_o    = h2_q;
  assign r2_o    = r2_q;
  assign op_o    = op_q;
endmodule

@@ hdl/vge_div.sv @@
// ----------------------------------------------------------------------------
// vge_div
// Pipelined restoring divider: t = 3*h2/r2 in Q4.16, one quotient bit a stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vge_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [47:0]          h2_i,
  input  logic [63:0]          r2_i,
  input  logic                 op_i,
  output logic                 valid_o,
  output logic [19:0]          tq_o,
  output logic                 zero_o,
  output vge_pkg::vge_ctrl_t   ctrl_o
);
  import vge_pkg::*;

  localparam int unsigned NS = TQ_W + 1;

  logic              valid_q [NS];
  logic [REM_W-1:0]  rem_q   [NS];
  logic [R2_W-1:0]   r2_q    [NS];
  logic [TQ_W-1:0]   tq_q    [NS];
  logic              zero_q  [NS];
  vge_ctrl_t         ctrl_q  [NS];

  logic [NUM_W-1:0]  num;
  logic [REM_W-1:0]  dvd, lim;

  always_comb begin
    num = NUM_W'(h2_i) + (NUM_W'(h2_i) << 1);
    dvd = REM_W'(num) << 16;
    lim = REM_W'(r2_i) << TQ_W;
  end

  // entry stage: dividend set up, quotient of 16 or more flagged
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]            <= dvd;
      r2_q[0]             <= r2_i;
      tq_q[0]             <= '0;
      zero_q[0]           <= (dvd >= lim);
      ctrl_q[0].op        <= op_i;
      ctrl_q[0].near_zero <= !op_i && (h2_i < H2_W'(H2_SMALL));
    end
  end

  for (genvar j = 1; j < NS; j++) begin : g_bit
    localparam int unsigned B = TQ_W - j;
    logic [REM_W-1:0] sub;
    logic             take;

    always_comb begin
      sub  = REM_W'(r2_q[j-1]) << B;
      take = (rem_q[j-1] >= sub);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j] <= 1'b0;
      end else if (en_i) begin
        valid_q[j] <= valid_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= take ? rem_q[j-1] - sub : rem_q[j-1];
        tq_q[j]   <= tq_q[j-1] | (TQ_W'(take) << B);
        r2_q[j]   <= r2_q[j-1];
        zero_q[j] <= zero_q[j-1];
        ctrl_q[j] <= ctrl_q[j-1];
      end
    end
  end

  assign valid_o = valid_q[NS-1];
  assign tq_o    = tq_q[NS-1];
  assign zero_o  = zero_q[NS-1];
  assign ctrl_o  = ctrl_q[NS-1];
endmodule

@@ hdl/vge_interp.sv @@
// ----------------------------------------------------------------------------
// vge_interp
// exp(-t) from a segment table with linear interpolation, three stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vge_interp #(
  parameter int unsigned EXP_TABLE_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [19:0]          tq_i,
  input  logic                 zero_i,
  input  vge_pkg::vge_ctrl_t   ctrl_i,
  output logic                 valid_o,
  output logic [16:0]          e_o,
  output vge_pkg::vge_ctrl_t   ctrl_o
);
  import vge_pkg::*;

  localparam int unsigned BT    = EXP_TABLE_BITS;
  localparam int unsigned TAB_N = 1 << BT;
  localparam int unsigned P_W   = TQ_W + BT;
  localparam int unsigned S_W   = P_W - SEG_SH;
  localparam int unsigned PR_W  = E_W + F_W;
  localparam logic [PR_W-1:0] HALF_SPAN = PR_W'(3) << (SEG_SH - 1);

  logic [E_W-1:0] rom [TAB_N+1];
  for (genvar k = 0; k <= TAB_N; k++) begin : g_rom
    assign rom[k] = exp_entry(k, BT);
  end

  // stage A: segment index and offset within the segment
  logic [P_W-1:0]  p;
  logic [S_W-1:0]  s;
  logic [31:0]     sdiv, srem;
  logic [BT-1:0]   idx_q;
  logic [F_W-1:0]  f_q;
  logic            zero_a_q, valid_a_q;
  vge_ctrl_t       ctrl_a_q;

  always_comb begin
    p    = P_W'(tq_i) << BT;
    s    = p[P_W-1:SEG_SH];
    sdiv = div3(32'(s));
    srem = 32'(s) - (sdiv + (sdiv << 1));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      idx_q    <= sdiv[BT-1:0];
      f_q      <= {srem[1:0], p[SEG_SH-1:0]};
      zero_a_q <= zero_i || (sdiv >= 32'(TAB_N));
      ctrl_a_q <= ctrl_i;
    end
  end

  // stage B: table reads and slope product
  logic [BT:0]      ra0, ra1;
  logic [E_W-1:0]   d;
  logic [E_W-1:0]   e0_q;
  logic [PR_W-1:0]  prod_q;
  logic             zero_b_q, valid_b_q;
  vge_ctrl_t        ctrl_b_q;

  always_comb begin
    ra0 = {1'b0, idx_q};
    ra1 = ra0 + 1'b1;
    d   = rom[ra0] - rom[ra1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e0_q     <= rom[ra0];
      prod_q   <= PR_W'(d) * PR_W'(f_q);
      zero_b_q <= zero_a_q;
      ctrl_b_q <= ctrl_a_q;
    end
  end

  // stage C: rounded step over the segment span of 12 * 2^16
  logic [PR_W-1:0] rnd;
  logic [31:0]     step;
  logic [E_W-1:0]  e_q;
  logic            valid_c_q;
  vge_ctrl_t       ctrl_c_q;

  always_comb begin
    rnd  = prod_q + HALF_SPAN;
    step = div3(32'(rnd >> SEG_SH));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q      <= zero_b_q ? '0 : e0_q - step[E_W-1:0];
      ctrl_c_q <= ctrl_b_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
      valid_c_q <= valid_b_q;
    end
  end

  assign valid_o = valid_c_q;
  assign e_o     = e_q;
  assign ctrl_o  = ctrl_c_q;
endmodule

@@ hdl/gaussian_variogram_eval.sv @@
// ----------------------------------------------------------------------------
// gaussian_variogram_eval
// Gaussian covariance / semivariogram evaluator, fully pipelined.
// ----------------------------------------------------------------------------
// Input requests (operation, dx, dy) arrive on in_valid_i / in_stall_o and
// results (value, saturated) leave on out_valid_o / out_stall_i; a request
// moves when valid is high and stall is low. Nugget, sill and range are set
// through the write port (cfg_we_i, cfg_idx_i, cfg_data_i); the user must do
// so only while idle, as the block does not enforce it. One request is
// accepted every cycle unless the pipeline stalls. A request passes one
// squaring stage, an entry stage and 20 single-bit stages of the restoring
// divider for t, three stages of table lookup and interpolation, a scaling
// multiply, and rounding and saturation into the register on out_rsp_o.
// When the receiver stalls while a result is held, the whole pipeline freezes
// and in_stall_o rises in that cycle; nothing is dropped or repeated.
// Reset clears all valid bits and loads the register defaults (nugget 0.2,
// sill 1.0, range sqrt 3). No clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gaussian_variogram_eval #(
  parameter int unsigned EXP_TABLE_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  vge_pkg::vge_req_t   in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output vge_pkg::vge_rsp_t   out_rsp_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i
);
  import vge_pkg::*;

  logic [31:0] nugget_q, sill_q, range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nugget_q <= 32'd13107;
      sill_q   <= 32'd65536;
      range_q  <= 32'd113512;
    end else if (cfg_we_i) begin
      case (vge_cfg_e'(cfg_idx_i))
        CFG_NUGGET: nugget_q <= cfg_data_i;
        CFG_SILL:   sill_q   <= cfg_data_i;
        CFG_RANGE:  range_q  <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  logic            sq_valid, sq_op;
  logic [H2_W-1:0] sq_h2;
  logic [R2_W-1:0] sq_r2;

  vge_sq u_sq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .req_i   (in_req_i),
    .range_i (range_q),
    .valid_o (sq_valid),
    .h2_o    (sq_h2),
    .r2_o    (sq_r2),
    .op_o    (sq_op)
  );

  logic            dv_valid, dv_zero;
  logic [TQ_W-1:0] dv_tq;
  vge_ctrl_t       dv_ctrl;

  vge_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .h2_i    (sq_h2),
    .r2_i    (sq_r2),
    .op_i    (sq_op),
    .valid_o (dv_valid),
    .tq_o    (dv_tq),
    .zero_o  (dv_zero),
    .ctrl_o  (dv_ctrl)
  );

  logic           ip_valid;
  logic [E_W-1:0] ip_e;
  vge_ctrl_t      ip_ctrl;

  vge_interp #(
    .EXP_TABLE_BITS (EXP_TABLE_BITS)
  ) u_interp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_valid),
    .tq_i    (dv_tq),
    .zero_i  (dv_zero),
    .ctrl_i  (dv_ctrl),
    .valid_o (ip_valid),
    .e_o     (ip_e),
    .ctrl_o  (ip_ctrl)
  );

  // scale by (sill - nugget)
  logic signed [32:0] diff;
  logic        [E_W-1:0] ew;
  logic signed [50:0] prod_q;
  logic               mul_valid_q;
  vge_ctrl_t          mul_ctrl_q;

  always_comb begin
    diff = 33'($signed(sill_q)) - 33'($signed(nugget_q));
    ew   = ip_ctrl.op ? E_ONE - ip_e : ip_e;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q     <= 51'(diff * $signed({1'b0, ew}));
      mul_ctrl_q <= ip_ctrl;
    end
  end

  // round half up to Q16.16, add nugget for the semivariogram, sill for a near-zero covariance, clip
  logic signed [50:0] rsum;
  logic signed [35:0] res;
  vge_rsp_t           rsp_d, rsp_q;

  always_comb begin
    rsum = prod_q + 51'sd32768;
    res  = 36'(rsum >>> 16);
    if (mul_ctrl_q.op) res = res + 36'($signed(nugget_q));
    if (mul_ctrl_q.near_zero) res = 36'($signed(sill_q));
    if (res > 36'sh07FFF_FFFF) begin
      rsp_d.value     = 32'sh7FFF_FFFF;
      rsp_d.saturated = 1'b1;
    end else if (res < -36'sh08000_0000) begin
      rsp_d.value     = 32'sh8000_0000;
      rsp_d.saturated = 1'b1;
    end else begin
      rsp_d.value     = res[31:0];
      rsp_d.saturated = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      mul_valid_q <= ip_valid;
      out_valid_q <= mul_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;
endmodule

@@ hdl/vge_chk.sv @@
// ----------------------------------------------------------------------------
// vge_chk
// Port-level checks for the variogram evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gaussian_variogram_eval_macros.svh"

module vge_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input vge_pkg::vge_rsp_t out_rsp_o
);
  import vge_pkg::*;

  // held result stays put
  `VGE_ASSERT_DEF(a_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o), "result changed while stalled")
  // input only backs up behind a stalled result
  `VGE_ASSERT_DEF(a_bp, in_stall_o |-> out_valid_o && out_stall_i, "input stalled without output stall")
  // a clipped result sits on a rail
  `VGE_ASSERT_DEF(a_sat, out_valid_o && out_rsp_o.saturated |-> out_rsp_o.value == 32'sh7FFF_FFFF || out_rsp_o.value == 32'sh8000_0000, "saturated flag off the rails")
endmodule

bind gaussian_variogram_eval vge_chk u_vge_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

@@ sim/gaussian_variogram_eval_tb.sv @@
// ----------------------------------------------------------------------------
// gaussian_variogram_eval_tb
// Self-checking bench for the Gaussian covariance / semivariogram evaluator.
// ----------------------------------------------------------------------------
// A scoreboard class predicts every accepted request from the offset, the
// operation and the current nugget, sill and range. It compares each result
// with the oldest prediction. Directed requests cover the extreme offsets,
// small distances, large arguments, a zero range, equal nugget and sill, and
// overflow. Random requests follow under several register settings, with
// random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gaussian_variogram_eval_tb;
  import vge_pkg::*;

  localparam logic OP_COV  = 1'b0;
  localparam logic OP_SEMI = 1'b1;
  localparam int unsigned TAB_BITS = 8;
  localparam int unsigned TAB_N    = 1 << TAB_BITS;
  localparam longint unsigned T_SPAN = 64'd12 << 16;
  localparam int DRAIN_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 5000;

  class variogram_scoreboard;
    logic [31:0] nugget, sill, range_q;
    longint unsigned exp_tab [TAB_N + 1];
    vge_rsp_t pending[$];
    int errors;

    function new();
      longint unsigned y, even, odd, term, v;
      nugget = 32'd13107;
      sill = 32'd65536;
      range_q = 32'd113512;
      errors = 0;
      for (int k = 0; k <= TAB_N; k++) begin
        y = ((64'd3 * k) << 30) + 64'd2 * TAB_N;
        y = y / (64'd4 * TAB_N);
        even = 64'd1 << 30;
        odd = 0;
        term = 64'd1 << 30;
        for (int j = 1; j <= 24; j++) begin
          term = ((term * y) >> 30) / j;
          if (j % 2 == 1) odd += term;
          else even += term;
        end
        v = (even > odd) ? even - odd : 0;
        for (int j = 0; j < 4; j++) v = (v * v + (64'd1 << 29)) >> 30;
        exp_tab[k] = (v + 8192) >> 14;
      end
    endfunction

    // exp(-3*h2/r2) in Q0.16
    function longint unsigned gauss_exp(longint unsigned h2, longint unsigned r2);
      longint unsigned num, q, rem, tq, p, seg, f, d;
      num = 3 * h2;
      q = num / r2;
      rem = num % r2;
      if (q >= 12) return 0;
      tq = q;
      for (int b = 0; b < 16; b++) begin
        if (rem >= r2 - rem) begin
          rem -= r2 - rem;
          tq = (tq << 1) | 1;
        end else begin
          rem += rem;
          tq <<= 1;
        end
      end
      p = tq * TAB_N;
      seg = p / T_SPAN;
      f = p % T_SPAN;
      if (seg >= TAB_N) return 0;
      d = exp_tab[seg] - exp_tab[seg + 1];
      return exp_tab[seg] - (d * f + T_SPAN / 2) / T_SPAN;
    endfunction

    function void note_request(vge_req_t r);
      longint dx, dy, nug, sl, diff, res;
      longint unsigned h2, rr, e;
      vge_rsp_t x;
      dx = r.dx;
      dy = r.dy;
      nug = $signed(nugget);
      sl = $signed(sill);
      rr = (range_q == 0) ? 1 : range_q;
      h2 = dx * dx + dy * dy;
      diff = sl - nug;
      if (r.operation == OP_COV && h2 < 430) begin
        res = sl;
      end else begin
        e = gauss_exp(h2, rr * rr);
        if (r.operation == OP_COV) res = (diff * longint'(e) + 32768) >>> 16;
        else res = ((diff * (65536 - longint'(e)) + 32768) >>> 16) + nug;
      end
      x.saturated = 1'b0;
      if (res > 64'sd2147483647) begin
        res = 64'sd2147483647;
        x.saturated = 1'b1;
      end else if (res < -64'sd2147483648) begin
        res = -64'sd2147483648;
        x.saturated = 1'b1;
      end
      x.value = res[31:0];
      pending.push_back(x);
    endfunction

    function void check_result(vge_rsp_t got);
      vge_rsp_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result value=%0d sat=%0b", $time, got.value,
                 got.saturated);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.value !== want.value) begin
        $display("%0t: value mismatch expected %0d actual %0d", $time, want.value,
                 got.value);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $display("%0t: saturated mismatch expected %0b actual %0b", $time,
                 want.saturated, got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i, cfg_we_i;
  vge_req_t in_req_i;
  vge_rsp_t out_rsp_o;
  logic [1:0] cfg_idx_i;
  logic [31:0] cfg_data_i;

  variogram_scoreboard sb = new();
  int idle_cycles = 0;
  int stall_left = 0;
  bit stall_quiet = 0;

  gaussian_variogram_eval i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // acceptance monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_request(in_req_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_rsp_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // result-side stalls: mostly short, a few long, with quiet stretches
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      if ($urandom_range(0, 99) == 0) stall_quiet <= !stall_quiet;
      if (!stall_quiet && $urandom_range(0, 9) < 3)
        stall_left <= ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3) : $urandom_range(15, 60);
    end
  end

  task automatic write_reg(vge_cfg_e idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_NUGGET: sb.nugget = data;
      CFG_SILL:   sb.sill = data;
      default:    sb.range_q = data;
    endcase
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_model(logic [31:0] nug, logic [31:0] sl, logic [31:0] rng);
    wait_drained();
    write_reg(CFG_NUGGET, nug);
    write_reg(CFG_SILL, sl);
    write_reg(CFG_RANGE, rng);
  endtask

  // one request; the gap goes before it with valid low
  task automatic send_request(logic op, logic [23:0] dx, logic [23:0] dy, int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= '{operation: op, dx: dx, dy: dy};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic logic [23:0] rand_offset();
    case ($urandom_range(0, 3))
      0: return 24'($urandom());
      1: return 24'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      2: return 24'($signed($urandom_range(0, 64)) - 32);
      default: return 24'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
    endcase
  endfunction

  function automatic int rand_gap(int n);
    if (n % 100 < 20) return 0;
    if ($urandom_range(0, 9) < 6) return 0;
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  task automatic directed_set();
    send_request(OP_COV, 24'h7FFFFF, 24'h7FFFFF, 0);
    send_request(OP_SEMI, 24'h800000, 24'h800000, 0);
    send_request(OP_COV, 24'h000000, 24'h000000, 0);
    send_request(OP_SEMI, 24'h000000, 24'h000000, 1);
    send_request(OP_COV, 24'd14, 24'd14, 0);
    send_request(OP_COV, 24'd15, 24'd15, 0);
    send_request(OP_SEMI, 24'd65536, 24'hFF0000, 0);
    send_request(OP_COV, 24'hFE0000, 24'd0, 2);
    send_request(OP_SEMI, 24'd0, 24'h0003_8000, 0);
    send_request(OP_COV, 24'h0004_0000, 24'h0004_0000, 0);
  endtask

  initial begin
    logic [31:0] nug, sl, rng;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_NUGGET;
    cfg_data_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // defaults after reset
    directed_set();
    in_valid_i <= 1'b0;
    // equal nugget and sill
    set_model(32'd40000, 32'd40000, 32'd65536);
    directed_set();
    in_valid_i <= 1'b0;
    // zero range and overflow in both directions
    set_model(32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
    directed_set();
    in_valid_i <= 1'b0;
    set_model(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    directed_set();
    in_valid_i <= 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      if ($urandom_range(0, 3) == 0) begin
        nug = $urandom();
        sl = $urandom();
      end else begin
        nug = 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
        sl = 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      end
      rng = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(4000, 400000);
      set_model(nug, sl, rng);
      for (int n = 0; n < 110; n++) begin
        if (ph == 1 && n == 50) begin
          in_valid_i <= 1'b0;
          while (sb.pending.size() != 0) @(posedge clk_i);
        end
        send_request($urandom_range(0, 1), rand_offset(), rand_offset(), rand_gap(n));
      end
      in_valid_i <= 1'b0;
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
